// ===== design/lrb_pkg.sv =====
// shared types, state codes and register indexes for the link reconnect supervisor
// no dependencies
`default_nettype none

package lrb_pkg;

    localparam int unsigned STATE_W = 3;
    localparam int unsigned DELAY_W = 31;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ADDR_W  = 2;

    localparam logic [STATE_W-1:0] ST_DISCONNECTED = 3'd0;
    localparam logic [STATE_W-1:0] ST_CONNECTING   = 3'd1;
    localparam logic [STATE_W-1:0] ST_CONNECTED    = 3'd2;
    localparam logic [STATE_W-1:0] ST_BACKOFF      = 3'd3;
    localparam logic [STATE_W-1:0] ST_NOCREDS      = 3'd4;

    localparam logic [ADDR_W-1:0] REG_CREDENTIALS   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_INITIAL_DELAY = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_DELAY     = 2'd2;
    localparam logic [ADDR_W-1:0] REG_TIMEOUT       = 2'd3;

    localparam logic               CMD_START          = 1'b1;
    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST  = 31'd1000;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST      = 31'd30000;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST        = 32'd15000;

    typedef struct packed {
        logic               credentials_present;
        logic [DELAY_W-1:0] initial_retry_delay_ms;
        logic [DELAY_W-1:0] max_retry_delay_ms;
        logic [TIME_W-1:0]  connect_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0] link_state;
        logic               start_attempt;
        logic               drop_link;
        logic [DELAY_W-1:0] retry_delay_ms;
    } result_t;

endpackage

`default_nettype wire

// ===== design/lrb_cfg.sv =====
// configuration register bank of the link reconnect supervisor
// depends on lrb_pkg
`default_nettype none

module lrb_cfg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lrb_pkg::ADDR_W-1:0]   cfg_addr,
    input  wire logic [lrb_pkg::TIME_W-1:0]   cfg_wdata,
    output lrb_pkg::cfg_t                     cfg
);

    lrb_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.credentials_present    <= 1'b0;
            cfg_reg.initial_retry_delay_ms <= lrb_pkg::INITIAL_DELAY_RST;
            cfg_reg.max_retry_delay_ms     <= lrb_pkg::MAX_DELAY_RST;
            cfg_reg.connect_timeout_ms     <= lrb_pkg::TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lrb_pkg::REG_CREDENTIALS: begin
                    cfg_reg.credentials_present <= cfg_wdata[0];
                end
                lrb_pkg::REG_INITIAL_DELAY: begin
                    cfg_reg.initial_retry_delay_ms <= cfg_wdata[lrb_pkg::DELAY_W-1:0];
                end
                lrb_pkg::REG_MAX_DELAY: begin
                    cfg_reg.max_retry_delay_ms <= cfg_wdata[lrb_pkg::DELAY_W-1:0];
                end
                lrb_pkg::REG_TIMEOUT: begin
                    cfg_reg.connect_timeout_ms <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/lrb_core.sv =====
// link state machine with backoff delay; computes one result per word and updates state
// depends on lrb_pkg
`default_nettype none

module lrb_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire lrb_pkg::item_t  item,
    input  wire lrb_pkg::cfg_t   cfg,
    output lrb_pkg::result_t     result
);

    logic [lrb_pkg::STATE_W-1:0] state_reg, state_next;
    logic [lrb_pkg::TIME_W-1:0]  last_attempt_reg, last_attempt_next;
    logic [lrb_pkg::TIME_W-1:0]  attempt_start_reg, attempt_start_next;
    logic [lrb_pkg::DELAY_W-1:0] delay_reg, delay_next;

    logic [lrb_pkg::TIME_W-1:0]  since_last;
    logic [lrb_pkg::TIME_W-1:0]  since_start;
    logic [lrb_pkg::TIME_W-1:0]  doubled;
    logic [lrb_pkg::DELAY_W-1:0] capped;
    logic                        start;
    logic                        drop;

    assign since_last  = item.now_ms - last_attempt_reg;
    assign since_start = item.now_ms - attempt_start_reg;
    assign doubled     = {delay_reg, 1'b0};
    assign capped      = (doubled < {1'b0, cfg.max_retry_delay_ms})
                         ? doubled[lrb_pkg::DELAY_W-1:0] : cfg.max_retry_delay_ms;

    always_comb begin
        state_next         = state_reg;
        last_attempt_next  = last_attempt_reg;
        attempt_start_next = attempt_start_reg;
        delay_next         = delay_reg;
        start              = 1'b0;
        drop               = 1'b0;
        if (item.cmd == lrb_pkg::CMD_START) begin
            drop = 1'b1;
            if (!cfg.credentials_present) begin
                state_next = lrb_pkg::ST_NOCREDS;
            end else begin
                attempt_start_next = item.now_ms;
                state_next         = lrb_pkg::ST_CONNECTING;
                start              = 1'b1;
            end
        end else begin
            case (state_reg)
                lrb_pkg::ST_CONNECTED: begin
                    if (!item.link_up) begin
                        state_next        = lrb_pkg::ST_DISCONNECTED;
                        delay_next        = cfg.initial_retry_delay_ms;
                        last_attempt_next = item.now_ms;
                    end
                end
                lrb_pkg::ST_DISCONNECTED, lrb_pkg::ST_BACKOFF: begin
                    if (since_last >= {1'b0, delay_reg}) begin
                        attempt_start_next = item.now_ms;
                        state_next         = lrb_pkg::ST_CONNECTING;
                        start              = 1'b1;
                    end
                end
                lrb_pkg::ST_CONNECTING: begin
                    if (item.link_up) begin
                        state_next = lrb_pkg::ST_CONNECTED;
                    end else if (since_start >= cfg.connect_timeout_ms) begin
                        drop              = 1'b1;
                        state_next        = lrb_pkg::ST_BACKOFF;
                        last_attempt_next = item.now_ms;
                        delay_next        = capped;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= lrb_pkg::ST_DISCONNECTED;
            last_attempt_reg  <= '0;
            attempt_start_reg <= '0;
            delay_reg         <= lrb_pkg::INITIAL_DELAY_RST;
        end else if (advance) begin
            state_reg         <= state_next;
            last_attempt_reg  <= last_attempt_next;
            attempt_start_reg <= attempt_start_next;
            delay_reg         <= delay_next;
        end
    end

    assign result.link_state     = state_next;
    assign result.start_attempt  = start;
    assign result.drop_link      = drop;
    assign result.retry_delay_ms = delay_next;

endmodule

`default_nettype wire

// ===== design/link_reconnect_backoff_fsm.sv =====
// top level of the link reconnect supervisor: input word register, core, result register
// depends on lrb_pkg, lrb_cfg and lrb_core
//
// Input words (s_cmd, s_now_ms, s_link_up) arrive on a valid/ready channel; each
// one is either a start command or a periodic tick. Every word yields exactly one
// result word on the m_ channel: the link state after the word, attempt-start and
// link-drop flags, and the current retry delay.
// The configuration port writes one register per cycle with cfg_wr_en high. The
// user must write it only while the block is idle; the block does not enforce this.
// A write made while idle takes effect on the next word. An accepted word sits in
// the input register, then passes through the state update into the result register.
// Throughput is one word per cycle while m_ready stays high, bounded by the single
// state update per cycle. Reset (aresetn low, synchronous) empties both registers,
// returns the link to disconnected with the 1000 ms default delay and loads the
// default registers. When the receiver stalls, the result register holds its word,
// the input register holds one more, and s_ready drops until m_ready returns.
`default_nettype none

module link_reconnect_backoff_fsm (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output wire logic                          s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [lrb_pkg::TIME_W-1:0]    s_now_ms,
    input  wire logic                          s_link_up,
    output wire logic                          m_valid,
    input  wire logic                          m_ready,
    output wire logic [lrb_pkg::STATE_W-1:0]   m_link_state,
    output wire logic                          m_start_attempt,
    output wire logic                          m_drop_link,
    output wire logic [lrb_pkg::DELAY_W-1:0]   m_retry_delay_ms,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lrb_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [lrb_pkg::TIME_W-1:0]    cfg_wdata
);

    lrb_pkg::cfg_t    cfg;
    lrb_pkg::item_t   item_reg;
    lrb_pkg::result_t result;
    lrb_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             accept;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    lrb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lrb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.cmd     <= s_cmd;
            item_reg.now_ms  <= s_now_ms;
            item_reg.link_up <= s_link_up;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_link_state     = result_reg.link_state;
    assign m_start_attempt  = result_reg.start_attempt;
    assign m_drop_link      = result_reg.drop_link;
    assign m_retry_delay_ms = result_reg.retry_delay_ms;

endmodule

`default_nettype wire

// ===== dv/link_supervisor_checker.sv =====
// checker for the link reconnect supervisor: follows config writes, predicts each result word
// from accepted input words and compares it field by field with what the block returns
// depends on lrb_pkg
module link_supervisor_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [lrb_pkg::TIME_W-1:0]    s_now_ms,
    input  logic                          s_link_up,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [lrb_pkg::STATE_W-1:0]   m_link_state,
    input  logic                          m_start_attempt,
    input  logic                          m_drop_link,
    input  logic [lrb_pkg::DELAY_W-1:0]   m_retry_delay_ms,
    input  logic                          cfg_wr_en,
    input  logic [lrb_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [lrb_pkg::TIME_W-1:0]    cfg_wdata,
    output int                            mismatches,
    output int                            outstanding
);
    import lrb_pkg::*;

    cfg_t               regs;
    logic [STATE_W-1:0] link_state_q;
    logic [TIME_W-1:0]  last_attempt_q;
    logic [TIME_W-1:0]  attempt_start_q;
    logic [DELAY_W-1:0] retry_delay_q;
    result_t            expected_words[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_link_word(input logic cmd, input logic [TIME_W-1:0] now,
                                     input logic up, output result_t word);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] doubled;
        word.start_attempt = 1'b0;
        word.drop_link     = 1'b0;
        if (cmd == CMD_START) begin
            word.drop_link = 1'b1;
            if (!regs.credentials_present) begin
                link_state_q = ST_NOCREDS;
            end else begin
                attempt_start_q    = now;
                link_state_q       = ST_CONNECTING;
                word.start_attempt = 1'b1;
            end
        end else begin
            case (link_state_q)
                ST_CONNECTED: begin
                    if (!up) begin
                        link_state_q   = ST_DISCONNECTED;
                        retry_delay_q  = regs.initial_retry_delay_ms;
                        last_attempt_q = now;
                    end
                end
                ST_DISCONNECTED, ST_BACKOFF: begin
                    elapsed = now - last_attempt_q;
                    if (elapsed >= {1'b0, retry_delay_q}) begin
                        attempt_start_q    = now;
                        link_state_q       = ST_CONNECTING;
                        word.start_attempt = 1'b1;
                    end
                end
                ST_CONNECTING: begin
                    elapsed = now - attempt_start_q;
                    if (up) begin
                        link_state_q = ST_CONNECTED;
                    end else if (elapsed >= regs.connect_timeout_ms) begin
                        // capped doubling of the retry delay
                        doubled        = {retry_delay_q, 1'b0};
                        word.drop_link = 1'b1;
                        link_state_q   = ST_BACKOFF;
                        last_attempt_q = now;
                        if (doubled < {1'b0, regs.max_retry_delay_ms}) begin
                            retry_delay_q = doubled[DELAY_W-1:0];
                        end else begin
                            retry_delay_q = regs.max_retry_delay_ms;
                        end
                    end
                end
                default: ;
            endcase
        end
        word.link_state     = link_state_q;
        word.retry_delay_ms = retry_delay_q;
    endtask

    always @(posedge aclk) begin : track
        result_t want;
        result_t word;
        if (!aresetn) begin
            regs.credentials_present    = 1'b0;
            regs.initial_retry_delay_ms = INITIAL_DELAY_RST;
            regs.max_retry_delay_ms     = MAX_DELAY_RST;
            regs.connect_timeout_ms     = TIMEOUT_RST;
            link_state_q    = ST_DISCONNECTED;
            last_attempt_q  = '0;
            attempt_start_q = '0;
            retry_delay_q   = INITIAL_DELAY_RST;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CREDENTIALS:   regs.credentials_present    = cfg_wdata[0];
                    REG_INITIAL_DELAY: regs.initial_retry_delay_ms = cfg_wdata[DELAY_W-1:0];
                    REG_MAX_DELAY:     regs.max_retry_delay_ms     = cfg_wdata[DELAY_W-1:0];
                    REG_TIMEOUT:       regs.connect_timeout_ms     = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", m_link_state, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_link_state !== want.link_state)
                        report_mismatch("link_state", m_link_state, want.link_state);
                    if (m_start_attempt !== want.start_attempt)
                        report_mismatch("start_attempt", m_start_attempt, want.start_attempt);
                    if (m_drop_link !== want.drop_link)
                        report_mismatch("drop_link", m_drop_link, want.drop_link);
                    if (m_retry_delay_ms !== want.retry_delay_ms)
                        report_mismatch("retry_delay_ms", m_retry_delay_ms,
                                        want.retry_delay_ms);
                end
            end
            if (s_valid && s_ready) begin
                predict_link_word(s_cmd, s_now_ms, s_link_up, word);
                expected_words.push_back(word);
            end
        end
        outstanding = expected_words.size();
    end

endmodule

// ===== dv/testbench.sv =====
// top of the link reconnect supervisor bench: clock, reset, config writes, input words,
// result back-pressure and the verdict
// depends on lrb_pkg, link_reconnect_backoff_fsm and link_supervisor_checker
module testbench;
    import lrb_pkg::*;

    localparam logic CMD_TICK = ~CMD_START;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_cmd     = 1'b0;
    logic [TIME_W-1:0]   s_now_ms  = '0;
    logic                s_link_up = 1'b0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [STATE_W-1:0]  m_link_state;
    logic                m_start_attempt;
    logic                m_drop_link;
    logic [DELAY_W-1:0]  m_retry_delay_ms;
    logic                cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr  = '0;
    logic [TIME_W-1:0]   cfg_wdata = '0;
    int                  mismatches;
    int                  outstanding;
    int                  send_idle_pct = 28;
    int                  recv_idle_pct = 71;

    link_reconnect_backoff_fsm dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_now_ms         (s_now_ms),
        .s_link_up        (s_link_up),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_link_state     (m_link_state),
        .m_start_attempt  (m_start_attempt),
        .m_drop_link      (m_drop_link),
        .m_retry_delay_ms (m_retry_delay_ms),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    link_supervisor_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_now_ms         (s_now_ms),
        .s_link_up        (s_link_up),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_link_state     (m_link_state),
        .m_start_attempt  (m_start_attempt),
        .m_drop_link      (m_drop_link),
        .m_retry_delay_ms (m_retry_delay_ms),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_word(input logic cmd, input logic [TIME_W-1:0] now, input logic up);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_now_ms  <= now;
        s_link_up <= up;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold the sender off until every word in flight has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic cred, input logic [DELAY_W-1:0] init_ms,
                             input logic [DELAY_W-1:0] max_ms, input logic [TIME_W-1:0] tmo_ms);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_CREDENTIALS;
        cfg_wdata <= {31'($urandom()), cred};
        @(posedge aclk);
        cfg_addr  <= REG_INITIAL_DELAY;
        cfg_wdata <= {1'($urandom()), init_ms};
        @(posedge aclk);
        cfg_addr  <= REG_MAX_DELAY;
        cfg_wdata <= {1'($urandom()), max_ms};
        @(posedge aclk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= tmo_ms;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_words, input bit wide);
        logic [TIME_W-1:0] t;
        logic              up;
        logic              cmd;
        drain();
        if (wide) begin
            configure(1'b1, DELAY_W'($urandom()), DELAY_W'($urandom()), $urandom());
        end else begin
            configure($urandom_range(0, 9) != 0, DELAY_W'($urandom_range(1, 20)),
                      DELAY_W'($urandom_range(1, 300)), $urandom_range(1, 40));
        end
        t  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom();
        up = 1'b0;
        repeat (n_words) begin
            if ($urandom_range(0, 99) < 15) up = ~up;
            cmd = ($urandom_range(0, 99) < 4) ? CMD_START : CMD_TICK;
            if ($urandom_range(0, 99) == 0) t = $urandom();
            else if (wide) t = t + ($urandom() >> $urandom_range(1, 6));
            else t = t + $urandom_range(0, 12);
            send_word(cmd, t, up);
            if ($urandom_range(0, 249) == 0) drain();
        end
    endtask

    initial begin : stimulus
        logic [TIME_W-1:0] t;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // no credentials after reset
        send_word(CMD_START, 32'd0, 1'b0);
        send_word(CMD_TICK, 32'd50000, 1'b1);
        drain();
        configure(1'b1, INITIAL_DELAY_RST, MAX_DELAY_RST, TIMEOUT_RST);

        // attempt across the time wrap, timeout boundary, backoff boundary
        send_word(CMD_START, 32'hFFFF_F000, 1'b0);
        send_word(CMD_TICK, 32'h0000_2A97, 1'b0);
        send_word(CMD_TICK, 32'h0000_2A98, 1'b0);
        t = 32'h0000_2A98 + 32'd1999;
        send_word(CMD_TICK, t, 1'b1);
        send_word(CMD_TICK, t + 32'd1, 1'b1);
        t = t + 32'd1 + TIMEOUT_RST;
        send_word(CMD_TICK, t, 1'b1);
        send_word(CMD_TICK, t + 32'd6, 1'b0);
        t = t + 32'd7;
        send_word(CMD_START, t, 1'b1);
        // repeated timeouts until the delay hits the cap
        repeat (5) begin
            t = t + TIMEOUT_RST;
            send_word(CMD_TICK, t, 1'b0);
            t = t + {1'b0, MAX_DELAY_RST};
            send_word(CMD_TICK, t, 1'b0);
        end

        // zero delay and zero timeout
        drain();
        configure(1'b1, '0, '1, '0);
        send_word(CMD_START, t, 1'b0);
        send_word(CMD_TICK, t, 1'b1);
        send_word(CMD_TICK, t, 1'b0);
        send_word(CMD_TICK, t, 1'b0);
        send_word(CMD_TICK, t, 1'b0);

        // widest delay and timeout, initial delay above the cap
        drain();
        configure(1'b1, '1, 31'd1, '1);
        send_word(CMD_TICK, t, 1'b1);
        send_word(CMD_TICK, t + 32'd1, 1'b1);
        t = t + 32'd2;
        send_word(CMD_TICK, t, 1'b0);
        t = t + 32'h7FFF_FFFF;
        send_word(CMD_TICK, t, 1'b0);
        send_word(CMD_TICK, t - 32'd2, 1'b0);
        send_word(CMD_TICK, t - 32'd1, 1'b0);

        run_random_phase(375, 1'b0);
        run_random_phase(150, 1'b1);

        drain();
        send_idle_pct = 71;
        recv_idle_pct = 28;
        run_random_phase(375, 1'b0);
        run_random_phase(375, 1'b0);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(150, 1'b1);
        run_random_phase(375, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("link_reconnect_backoff_fsm verification clean");
        end else begin
            $display("link_reconnect_backoff_fsm verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("link_reconnect_backoff_fsm verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lrb_pkg.sv
design/lrb_cfg.sv
design/lrb_core.sv
design/link_reconnect_backoff_fsm.sv
dv/link_supervisor_checker.sv
dv/testbench.sv
